// ===== rtl/lbc_pkg.sv =====
// shared types and constants of the line segment window clipper
package lbc_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 20;
  // quotient bits: ratio magnitude runs up to 2.0, so two integer bits
  localparam int QUO_BITS      = FRACTION_BITS + 2;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int RATIO_BITS    = QUO_BITS + 1;
  localparam int T_BITS        = FRACTION_BITS + 1;
  localparam int PROD_BITS     = COORD_BITS + T_BITS;
  localparam int ROUND_BITS    = PROD_BITS - FRACTION_BITS;

  localparam logic [QUO_BITS-1:0] RATIO_LIM = QUO_BITS'(2) << FRACTION_BITS;
  localparam logic signed [RATIO_BITS-1:0] FIX_ONE = RATIO_BITS'(1) << FRACTION_BITS;

  // config register indexes
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  // one boundary lane of the divider chain
  typedef struct packed {
    logic                   pzero;
    logic                   pneg;
    logic                   neg;
    logic                   sat;
    logic                   rej;
    logic [COORD_BITS-1:0]  dvs;
    logic [COORD_BITS-1:0]  rem;
    logic [1:0]             num;
    logic [QUO_BITS-1:0]    quo;
  } lane_t;

  typedef struct packed {
    logic                          valid;
    logic signed [COORD_BITS-1:0]  x1;
    logic signed [COORD_BITS-1:0]  y1;
    logic signed [DIFF_BITS-1:0]   dx;
    logic signed [DIFF_BITS-1:0]   dy;
    lane_t [3:0]                   ln;
  } item_t;

endpackage

// ===== rtl/lbc_div_cell.sv =====
// one restoring division step for all four boundary lanes
module lbc_div_cell import lbc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  item_t in_item,
  output item_t out_item
);

  item_t item_r;
  item_t item_nxt;

  always_comb begin
    logic [COORD_BITS:0] rs;
    item_nxt = in_item;
    for (int i = 0; i < 4; i++) begin
      rs = {in_item.ln[i].rem, in_item.ln[i].num[1]};
      item_nxt.ln[i].num = {in_item.ln[i].num[0], 1'b0};
      if (rs >= {1'b0, in_item.ln[i].dvs}) begin
        item_nxt.ln[i].rem = COORD_BITS'(rs - {1'b0, in_item.ln[i].dvs});
        item_nxt.ln[i].quo = {in_item.ln[i].quo[QUO_BITS-2:0], 1'b1};
      end else begin
        item_nxt.ln[i].rem = rs[COORD_BITS-1:0];
        item_nxt.ln[i].quo = {in_item.ln[i].quo[QUO_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else begin
      item_r <= item_nxt;
    end
  end

  assign out_item = item_r;

endmodule

// ===== rtl/lbc_finish.sv =====
// ratio limiting, entry/exit selection, endpoint scaling and result register
module lbc_finish import lbc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  item_t                         in_item,
  output logic                          out_strobe,
  output logic                          out_visible,
  output logic signed [COORD_BITS-1:0]  out_clipped_start_x,
  output logic signed [COORD_BITS-1:0]  out_clipped_start_y,
  output logic signed [COORD_BITS-1:0]  out_clipped_end_x,
  output logic signed [COORD_BITS-1:0]  out_clipped_end_y
);

  // stage a: parameters
  logic                          a_valid_r;
  logic                          a_ok_r, a_ok_nxt;
  logic                          a_use_en_r, a_use_en_nxt;
  logic                          a_use_ex_r, a_use_ex_nxt;
  logic [T_BITS-1:0]             a_ten_r, a_ten_nxt;
  logic [T_BITS-1:0]             a_tex_r, a_tex_nxt;
  logic signed [COORD_BITS-1:0]  a_x1_r, a_y1_r;
  logic signed [DIFF_BITS-1:0]   a_dx_r, a_dy_r;

  always_comb begin
    logic signed [RATIO_BITS-1:0] en;
    logic signed [RATIO_BITS-1:0] ex;
    logic signed [RATIO_BITS-1:0] r;
    logic [QUO_BITS-1:0]          m;
    en = '0;
    ex = FIX_ONE;
    a_ok_nxt = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (in_item.ln[i].sat || in_item.ln[i].quo > RATIO_LIM) m = RATIO_LIM;
      else m = in_item.ln[i].quo;
      r = in_item.ln[i].neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (in_item.ln[i].pzero) begin
        if (in_item.ln[i].rej) a_ok_nxt = 1'b0;
      end else if (in_item.ln[i].pneg) begin
        if (r > en) en = r;
      end else begin
        if (r < ex) ex = r;
      end
    end
    if (en > ex) a_ok_nxt = 1'b0;
    a_use_en_nxt = en > 0;
    a_use_ex_nxt = ex < FIX_ONE;
    a_ten_nxt = en[T_BITS-1:0];
    a_tex_nxt = ex[T_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_ok_r     <= a_ok_nxt;
    a_use_en_r <= a_use_en_nxt;
    a_use_ex_r <= a_use_ex_nxt;
    a_ten_r    <= a_ten_nxt;
    a_tex_r    <= a_tex_nxt;
    a_x1_r     <= in_item.x1;
    a_y1_r     <= in_item.y1;
    a_dx_r     <= in_item.dx;
    a_dy_r     <= in_item.dy;
  end

  // stage b: products of direction magnitude and parameter
  logic                          b_valid_r;
  logic                          b_ok_r, b_use_en_r, b_use_ex_r;
  logic                          b_nx_r, b_ny_r;
  logic signed [COORD_BITS-1:0]  b_x1_r, b_y1_r, b_x2_r, b_y2_r;
  logic [PROD_BITS-1:0]          b_sx_r, b_sy_r, b_ex_r, b_ey_r;
  logic [DIFF_BITS-1:0]          adx, ady;
  logic [COORD_BITS-1:0]         mdx, mdy;

  assign adx = a_dx_r[DIFF_BITS-1] ? DIFF_BITS'(-a_dx_r) : DIFF_BITS'(a_dx_r);
  assign ady = a_dy_r[DIFF_BITS-1] ? DIFF_BITS'(-a_dy_r) : DIFF_BITS'(a_dy_r);
  assign mdx = adx[COORD_BITS-1:0];
  assign mdy = ady[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_ok_r     <= a_ok_r;
    b_use_en_r <= a_use_en_r;
    b_use_ex_r <= a_use_ex_r;
    b_nx_r     <= a_dx_r[DIFF_BITS-1];
    b_ny_r     <= a_dy_r[DIFF_BITS-1];
    b_x1_r     <= a_x1_r;
    b_y1_r     <= a_y1_r;
    b_x2_r     <= COORD_BITS'(a_x1_r + a_dx_r);
    b_y2_r     <= COORD_BITS'(a_y1_r + a_dy_r);
    b_sx_r     <= PROD_BITS'(mdx) * PROD_BITS'(a_ten_r);
    b_sy_r     <= PROD_BITS'(mdy) * PROD_BITS'(a_ten_r);
    b_ex_r     <= PROD_BITS'(mdx) * PROD_BITS'(a_tex_r);
    b_ey_r     <= PROD_BITS'(mdy) * PROD_BITS'(a_tex_r);
  end

  // stage c: round half away from zero and offset from the start point
  function automatic logic [COORD_BITS-1:0] offs(input logic [COORD_BITS-1:0] base,
                                                 input logic [PROD_BITS-1:0] prod,
                                                 input logic neg);
    logic [PROD_BITS-1:0]  s;
    logic [ROUND_BITS-1:0] r;
    s = prod + (PROD_BITS'(1) << (FRACTION_BITS - 1));
    r = s[PROD_BITS-1:FRACTION_BITS];
    if (neg) offs = base - r[COORD_BITS-1:0];
    else offs = base + r[COORD_BITS-1:0];
  endfunction

  logic                   vis_nxt;
  logic [COORD_BITS-1:0]  sx_nxt, sy_nxt, ex_nxt, ey_nxt;

  always_comb begin
    vis_nxt = b_valid_r && b_ok_r;
    sx_nxt = b_x1_r;
    sy_nxt = b_y1_r;
    ex_nxt = b_x2_r;
    ey_nxt = b_y2_r;
    if (b_use_en_r) begin
      sx_nxt = offs(b_x1_r, b_sx_r, b_nx_r);
      sy_nxt = offs(b_y1_r, b_sy_r, b_ny_r);
    end
    if (b_use_ex_r) begin
      ex_nxt = offs(b_x1_r, b_ex_r, b_nx_r);
      ey_nxt = offs(b_y1_r, b_ey_r, b_ny_r);
    end
    if (!vis_nxt) begin
      sx_nxt = '0;
      sy_nxt = '0;
      ex_nxt = '0;
      ey_nxt = '0;
    end
  end

  logic strobe_r, vis_r;
  logic [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      vis_r    <= 1'b0;
    end else begin
      strobe_r <= b_valid_r;
      vis_r    <= vis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r <= sx_nxt;
    sy_r <= sy_nxt;
    ex_r <= ex_nxt;
    ey_r <= ey_nxt;
  end

  assign out_strobe          = strobe_r;
  assign out_visible         = vis_r;
  assign out_clipped_start_x = sx_r;
  assign out_clipped_start_y = sy_r;
  assign out_clipped_end_x   = ex_r;
  assign out_clipped_end_y   = ey_r;

endmodule

// ===== rtl/line_segment_window_clipper.sv =====
// top level of the line segment window clipper
// usage:
//  - a segment transaction is taken on each clock edge with start high; busy
//    is always low, so one segment per cycle is sustained
//  - the result shows on the out_ ports after the input stage, the divider chain
//    and the finishing stages, with out_strobe high for exactly one cycle; the receiver cannot stall
//  - the pipeline is the chain of 22 divider cells (one quotient bit per
//    cell, four boundary ratios side by side) plus one input stage and three
//    finishing stages (ratio select, multiply, round and output)
//  - out_visible low means rejected; the coordinates are then zero
//  - window registers are written through cfg_we/cfg_index/cfg_data; the user must
//    write them only while no segment is in flight, the block does not enforce it
//  - synchronous active-low reset empties the pipeline and loads the
//    default window 0..639 by 0..479
module line_segment_window_clipper import lbc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_start_x,
  input  logic signed [COORD_BITS-1:0]  in_start_y,
  input  logic signed [COORD_BITS-1:0]  in_end_x,
  input  logic signed [COORD_BITS-1:0]  in_end_y,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_data,
  output logic                          out_strobe,
  output logic                          out_visible,
  output logic signed [COORD_BITS-1:0]  out_clipped_start_x,
  output logic signed [COORD_BITS-1:0]  out_clipped_start_y,
  output logic signed [COORD_BITS-1:0]  out_clipped_end_x,
  output logic signed [COORD_BITS-1:0]  out_clipped_end_y
);

  logic signed [COORD_BITS-1:0] left_r, top_r, right_r, bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= COORD_BITS'(639);
      bottom_r <= COORD_BITS'(479);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   left_r   <= cfg_data;
        REG_TOP:    top_r    <= cfg_data;
        REG_RIGHT:  right_r  <= cfg_data;
        REG_BOTTOM: bottom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage: boundary terms and divider setup
  item_t s0_nxt;

  always_comb begin
    logic signed [DIFF_BITS-1:0] p [4];
    logic signed [DIFF_BITS-1:0] q [4];
    logic [DIFF_BITS-1:0]        ap, aq;
    logic [COORD_BITS-1:0]       mp, mq;
    s0_nxt = '0;
    s0_nxt.valid = start;
    s0_nxt.x1 = in_start_x;
    s0_nxt.y1 = in_start_y;
    s0_nxt.dx = DIFF_BITS'(in_end_x) - DIFF_BITS'(in_start_x);
    s0_nxt.dy = DIFF_BITS'(in_end_y) - DIFF_BITS'(in_start_y);
    p[0] = -s0_nxt.dx;
    p[1] = s0_nxt.dx;
    p[2] = -s0_nxt.dy;
    p[3] = s0_nxt.dy;
    q[0] = DIFF_BITS'(in_start_x) - DIFF_BITS'(left_r);
    q[1] = DIFF_BITS'(right_r) - DIFF_BITS'(in_start_x);
    q[2] = DIFF_BITS'(in_start_y) - DIFF_BITS'(top_r);
    q[3] = DIFF_BITS'(bottom_r) - DIFF_BITS'(in_start_y);
    for (int i = 0; i < 4; i++) begin
      ap = p[i][DIFF_BITS-1] ? DIFF_BITS'(-p[i]) : DIFF_BITS'(p[i]);
      aq = q[i][DIFF_BITS-1] ? DIFF_BITS'(-q[i]) : DIFF_BITS'(q[i]);
      mp = ap[COORD_BITS-1:0];
      mq = aq[COORD_BITS-1:0];
      s0_nxt.ln[i].pzero = (p[i] == 0);
      s0_nxt.ln[i].pneg  = p[i][DIFF_BITS-1];
      s0_nxt.ln[i].neg   = p[i][DIFF_BITS-1] != q[i][DIFF_BITS-1];
      s0_nxt.ln[i].rej   = q[i][DIFF_BITS-1];
      // ratio at or above 4.0 would overflow the quotient; it saturates anyway
      s0_nxt.ln[i].sat   = {2'b00, mq} >= {mp, 2'b00};
      s0_nxt.ln[i].dvs   = mp;
      s0_nxt.ln[i].rem   = COORD_BITS'(mq >> 2);
      s0_nxt.ln[i].num   = mq[1:0];
      s0_nxt.ln[i].quo   = '0;
    end
  end

  item_t chain [QUO_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= s0_nxt;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
    lbc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_item  (chain[k]),
      .out_item (chain[k+1])
    );
  end

  lbc_finish u_finish (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_item             (chain[QUO_BITS]),
    .out_strobe          (out_strobe),
    .out_visible         (out_visible),
    .out_clipped_start_x (out_clipped_start_x),
    .out_clipped_start_y (out_clipped_start_y),
    .out_clipped_end_x   (out_clipped_end_x),
    .out_clipped_end_y   (out_clipped_end_y)
  );

`ifndef SYNTHESIS
  a_vis_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_visible |-> out_strobe) else $error("visible without strobe");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_visible |-> out_clipped_start_x == 0 && out_clipped_start_y == 0
      && out_clipped_end_x == 0 && out_clipped_end_y == 0)
    else $error("rejected segment with nonzero coordinates");
  a_chain_moves: assert property (@(posedge clk) disable iff (!rst_n)
    chain[0].valid |-> ##1 chain[1].valid) else $error("divider chain dropped a segment");
`endif

endmodule

// ===== sim/line_segment_window_clipper_test.sv =====
// testbench of the line segment window clipper: random and corner segments checked against a clip predictor
module line_segment_window_clipper_test import lbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   visible;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_t;

  class clip_checker;
    coord_t win_left   = 0;
    coord_t win_top    = 0;
    coord_t win_right  = 639;
    coord_t win_bottom = 479;
    clip_t  pending_clips[$];
    int     errors = 0;
    int     checked = 0;

    static function longint abs_of(longint v);
      return v < 0 ? -v : v;
    endfunction

    // q/p with FRACTION_BITS fraction, truncated, saturated to +-2.0
    static function longint ratio(longint q, longint p);
      longint r;
      r = (abs_of(q) << FRACTION_BITS) / abs_of(p);
      if (r > (longint'(2) << FRACTION_BITS)) r = longint'(2) << FRACTION_BITS;
      return ((q < 0) != (p < 0)) ? -r : r;
    endfunction

    // d * t rounded half away from zero
    static function longint scaled(longint d, longint t);
      longint m;
      m = (abs_of(d) * t + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      return d < 0 ? -m : m;
    endfunction

    function clip_t predict_clip(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
      longint dx, dy, t_in, t_out, r;
      longint p[4];
      longint q[4];
      bit     ok;
      clip_t  c;
      dx = longint'(x2) - longint'(x1);
      dy = longint'(y2) - longint'(y1);
      p[0] = -dx; q[0] = longint'(x1) - longint'(win_left);
      p[1] = dx;  q[1] = longint'(win_right) - longint'(x1);
      p[2] = -dy; q[2] = longint'(y1) - longint'(win_top);
      p[3] = dy;  q[3] = longint'(win_bottom) - longint'(y1);
      t_in = 0;
      t_out = longint'(1) << FRACTION_BITS;
      ok = 1;
      for (int i = 0; i < 4; i++) begin
        if (p[i] == 0) begin
          if (q[i] < 0) ok = 0;
        end else begin
          r = ratio(q[i], p[i]);
          if (p[i] < 0) begin
            if (r > t_in) t_in = r;
          end else if (r < t_out) begin
            t_out = r;
          end
        end
      end
      if (t_in > t_out) ok = 0;
      c = '{0, 0, 0, 0, 0};
      if (ok) begin
        c.visible = 1;
        c.sx = x1; c.sy = y1; c.ex = x2; c.ey = y2;
        if (t_out < (longint'(1) << FRACTION_BITS)) begin
          c.ex = coord_t'(longint'(x1) + scaled(dx, t_out));
          c.ey = coord_t'(longint'(y1) + scaled(dy, t_out));
        end
        if (t_in > 0) begin
          c.sx = coord_t'(longint'(x1) + scaled(dx, t_in));
          c.sy = coord_t'(longint'(y1) + scaled(dy, t_in));
        end
      end
      return c;
    endfunction

    function void note_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
      pending_clips.push_back(predict_clip(x1, y1, x2, y2));
    endfunction

    function void mismatch(string what, longint want, longint got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_clip(clip_t got);
      clip_t want;
      if (pending_clips.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending, expected none actual %0d",
                 $time, got.visible);
        return;
      end
      want = pending_clips.pop_front();
      checked++;
      if (got.visible !== want.visible) mismatch("visible", want.visible, got.visible);
      if (got.sx !== want.sx) mismatch("clipped_start_x", want.sx, got.sx);
      if (got.sy !== want.sy) mismatch("clipped_start_y", want.sy, got.sy);
      if (got.ex !== want.ex) mismatch("clipped_end_x", want.ex, got.ex);
      if (got.ey !== want.ey) mismatch("clipped_end_y", want.ey, got.ey);
    endfunction
  endclass

  logic           clk = 0;
  logic           rst_n = 0;
  logic           start = 0;
  logic           busy;
  coord_t         in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic           cfg_we = 0;
  logic [1:0]     cfg_index = REG_LEFT;
  logic [COORD_BITS-1:0] cfg_data = 0;
  logic           out_strobe, out_visible;
  coord_t         out_clipped_start_x, out_clipped_start_y;
  coord_t         out_clipped_end_x, out_clipped_end_y;

  clip_checker clips = new();
  int visible_seen = 0;
  int windows_used = 1;

  line_segment_window_clipper dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      clips.note_segment(in_start_x, in_start_y, in_end_x, in_end_y);
    if (rst_n && out_strobe) begin
      clips.check_clip('{out_visible, out_clipped_start_x, out_clipped_start_y,
                         out_clipped_end_x, out_clipped_end_y});
      if (out_visible) visible_seen++;
    end
  end

  task automatic send_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    start <= 1;
    in_start_x <= x1; in_start_y <= y1; in_end_x <= x2; in_end_y <= y2;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 0;
    @(posedge clk);
    while (clips.pending_clips.size() != 0) @(posedge clk);
    // pipeline latency margin
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, coord_t val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_window(coord_t l, coord_t t, coord_t r, coord_t b);
    drain();
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    cfg_we <= 0;
    clips.win_left = l; clips.win_top = t; clips.win_right = r; clips.win_bottom = b;
    windows_used++;
    @(posedge clk);
  endtask

  // mostly near the window span, sometimes anywhere in the 16-bit range
  function automatic coord_t pick_coord(coord_t lo, coord_t hi);
    longint a, b, v;
    if ($urandom_range(0, 3) == 0) return coord_t'($urandom_range(0, 65535));
    a = lo < hi ? lo : hi;
    b = lo < hi ? hi : lo;
    v = a - 64 + longint'($urandom_range(0, 32'(b - a + 128)));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return coord_t'(v);
  endfunction

  task automatic random_segments(int count, bit no_gaps);
    int sent;
    int burst;
    coord_t x1, y1, x2, y2;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < count; i++) begin
        x1 = pick_coord(clips.win_left, clips.win_right);
        y1 = pick_coord(clips.win_top, clips.win_bottom);
        x2 = pick_coord(clips.win_left, clips.win_right);
        y2 = pick_coord(clips.win_top, clips.win_bottom);
        case ($urandom_range(0, 9))
          0: begin x2 = x1; y2 = y1; end
          1: y2 = y1;
          2: x2 = x1;
          default: ;
        endcase
        send_segment(x1, y1, x2, y2);
        sent++;
      end
      if (!no_gaps) pause($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // default window corner cases
    send_segment(100, 100, 200, 200);          // fully inside
    send_segment(-100, 240, 800, 240);         // horizontal crossing both sides
    send_segment(320, -50, 320, 600);          // vertical crossing both sides
    send_segment(300, 200, 300, 200);          // point inside
    send_segment(0, 479, 0, 479);              // point on a corner edge
    send_segment(640, 0, 640, 0);              // point just outside
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(32767, 32767, -32768, -32768);
    send_segment(-10, -10, -1, -500);          // fully outside
    send_segment(700, 10, 650, 400);           // parallel-ish outside right
    send_segment(-5, -5, 5, 5);                // entry clipped
    send_segment(630, 470, 650, 490);          // exit clipped
    send_segment(-1, 0, 1, 1);                 // rounding near half
    send_segment(0, 0, 639, 479);              // diagonal exactly on window
    pause(3);
    send_segment(-32768, 0, -32768, 0);
    send_segment(32767, 32767, 32767, 32767);
    send_segment(-300, 600, 900, -200);
    drain();

    random_segments(110, 0);

    set_window(-32768, -32768, 32767, 32767);   // full range window
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    random_segments(90, 0);

    set_window(5, 5, 5, 5);                     // single-point window
    send_segment(5, 5, 5, 5);
    send_segment(0, 0, 10, 10);
    random_segments(70, 0);

    set_window(100, 50, -100, 200);             // inverted window
    random_segments(50, 0);

    set_window(32767, 32767, 32767, 32767);
    random_segments(40, 0);

    set_window(-32768, -32768, -32700, -32700);
    random_segments(40, 1);                     // back to back, no gaps

    set_window(-200, -150, 300, 250);
    random_segments(100, 0);
    drain();                                    // sender waits for everything
    random_segments(60, 0);

    set_window(coord_t'($urandom_range(0, 65535)), coord_t'($urandom_range(0, 65535)),
               coord_t'($urandom_range(0, 65535)), coord_t'($urandom_range(0, 65535)));
    random_segments(40, 0);

    start <= 0;
    @(posedge clk);
    while (clips.pending_clips.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("checked %0d segments (%0d visible) over %0d window settings",
             clips.checked, visible_seen, windows_used);
    $display("settings included full range, single point, inverted and edge windows");
    if (clips.errors == 0 && clips.pending_clips.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #(20ns * 400000);
    $display("timeout with %0d results pending", clips.pending_clips.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lbc_pkg.sv
rtl/lbc_div_cell.sv
rtl/lbc_finish.sv
rtl/line_segment_window_clipper.sv
sim/line_segment_window_clipper_test.sv
